[rtl/pfim_pkg.sv]
// Package for the fragment ion mass block: sizes, codes, types and lookup functions.
package pfim_pkg;

    localparam int MAX_LOSSES = 8;
    localparam int MAX_CHARGE = 8;
    localparam int FRAC_BITS  = 24;

    localparam int MASS_W   = 48;
    localparam int LOSS_IW  = $clog2(MAX_LOSSES);
    localparam int LOSS_CW  = $clog2(MAX_LOSSES + 1);
    localparam int CHG_W    = 4;
    localparam int POS_W    = 10;
    localparam int RES_W    = 8;
    localparam int VAR_W    = 3;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 30;
    localparam int CONST_W  = 30;

    // Numerator range: mass, loss, charge correction and type offsets
    localparam int NUM_W     = 51;
    localparam int RADIX_W   = 8;
    localparam int DIV_STEPS = (NUM_W + RADIX_W - 1) / RADIX_W;
    localparam int QUO_W     = DIV_STEPS * RADIX_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int SUM_W     = QUO_W + 2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_ION_TYPE = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_RAD_EN   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_LOSS_CNT = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_PROTON   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CO       = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_NITROGEN = 3'd5;

    localparam logic [CONST_W-1:0] PROTON_RST   = 30'd16899296;
    localparam logic [CONST_W-1:0] CO_RST       = 30'd469676730;
    localparam logic [CONST_W-1:0] NITROGEN_RST = 30'd234932597;

    // Request codes
    localparam logic REQ_LOSS_WR = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    // Variant codes
    localparam logic [VAR_W-1:0] VAR_BASE     = 3'd0;
    localparam logic [VAR_W-1:0] VAR_RAD_SAME = 3'd1;
    localparam logic [VAR_W-1:0] VAR_RAD_MH   = 3'd2;
    localparam logic [VAR_W-1:0] VAR_RAD_PH   = 3'd3;
    localparam logic [VAR_W-1:0] VAR_RAD_P2H  = 3'd4;
    localparam logic [VAR_W-1:0] VAR_LOSS     = 3'd5;
    localparam logic [VAR_W-1:0] VAR_PREC_RAD = 3'd6;

    typedef enum logic [2:0] {
        ION_B, ION_Y, ION_A, ION_C, ION_Z, ION_X, ION_PREC, ION_IMM
    } t_ion_type;

    typedef enum logic [1:0] {
        K_BASE, K_RAD0, K_RAD1, K_LOSS
    } t_kind;

    typedef enum logic [1:0] {
        D_ZERO, D_MINUS_P, D_PLUS_P, D_PLUS_2P
    } t_delta;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_NUM, S_DIV, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic                write_loss;
        logic                load;
        logic                prep;
        logic                start;
        logic                step;
        logic                finish;
        t_kind               kind;
        logic [LOSS_IW-1:0]  idx;
        logic                last;
    } t_cmd;

    typedef struct packed {
        logic [1:0]          nv;
        logic [LOSS_CW-1:0]  nl;
        logic                skip;
    } t_status;

    // Number of radical variants of a type
    function automatic logic [1:0] rad_count(t_ion_type t);
        case (t)
            ION_B, ION_C, ION_Z, ION_X, ION_PREC: rad_count = 2'd1;
            ION_A:                                rad_count = 2'd2;
            default:                              rad_count = 2'd0;
        endcase
    endfunction

    // Variant code of an ion
    function automatic logic [VAR_W-1:0] variant_of(t_ion_type t, t_kind k);
        logic [VAR_W-1:0] v;
        v = VAR_BASE;
        case (k)
            K_BASE: v = VAR_BASE;
            K_LOSS: v = VAR_LOSS;
            K_RAD1: v = VAR_RAD_PH;
            K_RAD0: begin
                case (t)
                    ION_A, ION_Z: v = VAR_RAD_MH;
                    ION_C:        v = VAR_RAD_P2H;
                    ION_PREC:     v = VAR_PREC_RAD;
                    default:      v = VAR_RAD_SAME;
                endcase
            end
            default: v = VAR_BASE;
        endcase
        return v;
    endfunction

    // Proton offset of a radical variant against the base mass
    function automatic t_delta delta_of(t_ion_type t, t_kind k);
        t_delta d;
        d = D_ZERO;
        case (k)
            K_RAD0: begin
                case (t)
                    ION_A, ION_Z: d = D_MINUS_P;
                    ION_C:        d = D_PLUS_2P;
                    default:      d = D_ZERO;
                endcase
            end
            K_RAD1:  d = D_PLUS_P;
            default: d = D_ZERO;
        endcase
        return d;
    endfunction

endpackage

[rtl/pfim_if.sv]
// Channel interfaces: request, ion result and configuration write.
interface pfim_req_if;
    logic                               valid;
    logic                               ready;
    logic                               req_type;
    logic signed [pfim_pkg::MASS_W-1:0] mass_in;
    logic [pfim_pkg::LOSS_IW-1:0]       loss_slot;
    logic [pfim_pkg::POS_W-1:0]         fragment_number;
    logic [pfim_pkg::RES_W-1:0]         residue_code;
    logic [pfim_pkg::CHG_W-1:0]         charge_state;

    modport source (output valid, req_type, mass_in, loss_slot, fragment_number,
                    residue_code, charge_state, input ready);
    modport sink   (input valid, req_type, mass_in, loss_slot, fragment_number,
                    residue_code, charge_state, output ready);
endinterface

interface pfim_ion_if;
    logic                               valid;
    logic                               ready;
    logic signed [pfim_pkg::MASS_W-1:0] ion_mz;
    logic [pfim_pkg::VAR_W-1:0]         variant;
    logic [pfim_pkg::LOSS_IW-1:0]       loss_index;
    logic [pfim_pkg::POS_W-1:0]         ion_position;
    logic [pfim_pkg::CHG_W-1:0]         ion_charge;
    logic [pfim_pkg::RES_W-1:0]         residue_out;
    logic                               last_ion;

    modport source (output valid, ion_mz, variant, loss_index, ion_position,
                    ion_charge, residue_out, last_ion, input ready);
    modport sink   (input valid, ion_mz, variant, loss_index, ion_position,
                    ion_charge, residue_out, last_ion, output ready);
endinterface

interface pfim_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pfim_pkg::CFG_IW-1:0]  index;
    logic [pfim_pkg::CFG_DW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/pfim_dp.sv]
// Datapath: configuration and loss table, mass correction, radix-256 divider, output register.
module pfim_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pfim_req_if.sink            i_req,
    pfim_cfg_if.sink            i_cfg,
    input  pfim_pkg::t_cmd      i_cmd,
    output pfim_pkg::t_status   o_status,
    pfim_ion_if.source          o_ion
);

    localparam logic signed [pfim_pkg::SUM_W-1:0] SAT_HI =
        {{(pfim_pkg::SUM_W - pfim_pkg::MASS_W + 1){1'b0}}, {(pfim_pkg::MASS_W - 1){1'b1}}};
    localparam logic signed [pfim_pkg::SUM_W-1:0] SAT_LO = -SAT_HI - 1;

    // Configuration registers
    pfim_pkg::t_ion_type               r_type;
    logic                              r_rad_en;
    logic [pfim_pkg::LOSS_CW-1:0]      r_loss_cnt;
    logic [pfim_pkg::CONST_W-1:0]      r_proton;
    logic [pfim_pkg::CONST_W-1:0]      r_co;
    logic [pfim_pkg::CONST_W-1:0]      r_nitrogen;

    logic signed [pfim_pkg::MASS_W-1:0] r_loss [pfim_pkg::MAX_LOSSES];

    // Request registers
    logic signed [pfim_pkg::MASS_W-1:0] r_m;
    logic [pfim_pkg::POS_W-1:0]         r_pos;
    logic [pfim_pkg::RES_W-1:0]         r_res;
    logic [pfim_pkg::CHG_W-1:0]         r_z;
    logic signed [pfim_pkg::NUM_W-1:0]  r_base;
    logic signed [pfim_pkg::NUM_W-1:0]  r_hm;

    // Divider registers
    logic [pfim_pkg::QUO_W-1:0]         r_quo;
    logic [pfim_pkg::CHG_W-1:0]         r_rem;
    logic                               r_neg;
    logic                               r_addp;
    logic [pfim_pkg::VAR_W-1:0]         r_var;
    logic [pfim_pkg::LOSS_IW-1:0]       r_lidx;

    // Output registers
    logic signed [pfim_pkg::MASS_W-1:0] r_o_mass;
    logic [pfim_pkg::VAR_W-1:0]         r_o_var;
    logic [pfim_pkg::LOSS_IW-1:0]       r_o_lidx;
    logic [pfim_pkg::POS_W-1:0]         r_o_pos;
    logic [pfim_pkg::CHG_W-1:0]         r_o_chg;
    logic [pfim_pkg::RES_W-1:0]         r_o_res;
    logic                               r_o_last;

    logic [pfim_pkg::CHG_W-1:0]         w_z;
    logic signed [pfim_pkg::NUM_W-1:0]  w_m, w_p, w_co, w_n, n_base, w_delta, w_lossv, w_num;
    logic [pfim_pkg::CONST_W+pfim_pkg::CHG_W-1:0] w_hm_u;
    logic [pfim_pkg::NUM_W-1:0]         w_mag;
    logic [pfim_pkg::QUO_W-1:0]         n_quo;
    logic [pfim_pkg::CHG_W-1:0]         n_rem;
    logic signed [pfim_pkg::SUM_W-1:0]  w_q, w_sum;
    logic                               w_imm, w_prec;
    logic [pfim_pkg::POS_W:0]           w_min_pos;

    assign i_cfg.ready = 1'b1;

    // Clamp the requested charge to 1..MAX_CHARGE
    always_comb begin
        w_z = i_req.charge_state;
        if (w_z == '0)
            w_z = pfim_pkg::CHG_W'(1);
        else if (w_z > pfim_pkg::CHG_W'(pfim_pkg::MAX_CHARGE))
            w_z = pfim_pkg::CHG_W'(pfim_pkg::MAX_CHARGE);
    end

    // Type-dependent mass correction
    always_comb begin
        w_m    = pfim_pkg::NUM_W'(r_m);
        w_p    = pfim_pkg::NUM_W'(r_proton);
        w_co   = pfim_pkg::NUM_W'(r_co);
        w_n    = pfim_pkg::NUM_W'(r_nitrogen);
        w_hm_u = (pfim_pkg::CONST_W + pfim_pkg::CHG_W)'(r_z - 4'd1)
                 * (pfim_pkg::CONST_W + pfim_pkg::CHG_W)'(r_proton);
        case (r_type)
            pfim_pkg::ION_B, pfim_pkg::ION_Y: n_base = w_m + w_p;
            pfim_pkg::ION_A:    n_base = w_m + w_p - w_co;
            pfim_pkg::ION_C:    n_base = w_m + (w_p <<< 2) + w_n;
            pfim_pkg::ION_Z:    n_base = w_m - w_n - w_p;
            pfim_pkg::ION_X:    n_base = w_m + w_co - w_p;
            pfim_pkg::ION_PREC: n_base = w_m;
            default:            n_base = w_m - w_co + w_p;
        endcase
    end

    assign w_imm  = (r_type == pfim_pkg::ION_IMM);
    assign w_prec = (r_type == pfim_pkg::ION_PREC);
    assign w_min_pos = (pfim_pkg::POS_W + 1)'(r_z) + (pfim_pkg::POS_W + 1)'(r_z)
                       - (pfim_pkg::POS_W + 1)'(1);

    // Status for the controller
    always_comb begin
        o_status.nv   = r_rad_en ? pfim_pkg::rad_count(r_type) : 2'd0;
        o_status.nl   = (r_loss_cnt > pfim_pkg::LOSS_CW'(pfim_pkg::MAX_LOSSES))
                        ? pfim_pkg::LOSS_CW'(pfim_pkg::MAX_LOSSES) : r_loss_cnt;
        o_status.skip = !w_prec && (r_z > pfim_pkg::CHG_W'(1))
                        && ((w_imm ? (pfim_pkg::POS_W + 1)'(0) : {1'b0, r_pos}) < w_min_pos);
    end

    // Numerator of the current ion
    always_comb begin
        case (pfim_pkg::delta_of(r_type, i_cmd.kind))
            pfim_pkg::D_MINUS_P: w_delta = -w_p;
            pfim_pkg::D_PLUS_P:  w_delta = w_p;
            pfim_pkg::D_PLUS_2P: w_delta = w_p <<< 1;
            default:             w_delta = '0;
        endcase
        w_lossv = (i_cmd.kind == pfim_pkg::K_LOSS) ? pfim_pkg::NUM_W'(r_loss[i_cmd.idx]) : '0;
        w_num   = r_base + r_hm + w_delta - w_lossv;
        w_mag   = w_num[pfim_pkg::NUM_W-1] ? pfim_pkg::NUM_W'(-w_num) : pfim_pkg::NUM_W'(w_num);
    end

    // Eight quotient bits per cycle
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        for (int b = 0; b < pfim_pkg::RADIX_W; b++) begin
            n_rem = {n_rem[pfim_pkg::CHG_W-2:0], n_quo[pfim_pkg::QUO_W-1]};
            n_quo = {n_quo[pfim_pkg::QUO_W-2:0], 1'b0};
            if (n_rem >= r_z) begin
                n_rem    = n_rem - r_z;
                n_quo[0] = 1'b1;
            end
        end
    end

    // Apply sign and proton offset
    always_comb begin
        w_q   = r_neg ? -pfim_pkg::SUM_W'(r_quo) : pfim_pkg::SUM_W'(r_quo);
        w_sum = w_q + (r_addp ? pfim_pkg::SUM_W'(r_proton) : pfim_pkg::SUM_W'(0));
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type     <= pfim_pkg::ION_B;
            r_rad_en   <= 1'b0;
            r_loss_cnt <= '0;
            r_proton   <= pfim_pkg::PROTON_RST;
            r_co       <= pfim_pkg::CO_RST;
            r_nitrogen <= pfim_pkg::NITROGEN_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                pfim_pkg::CFG_ION_TYPE: r_type     <= pfim_pkg::t_ion_type'(i_cfg.data[2:0]);
                pfim_pkg::CFG_RAD_EN:   r_rad_en   <= i_cfg.data[0];
                pfim_pkg::CFG_LOSS_CNT: r_loss_cnt <= i_cfg.data[pfim_pkg::LOSS_CW-1:0];
                pfim_pkg::CFG_PROTON:   r_proton   <= i_cfg.data;
                pfim_pkg::CFG_CO:       r_co       <= i_cfg.data;
                pfim_pkg::CFG_NITROGEN: r_nitrogen <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Loss table, request capture, divider and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_loss)
            r_loss[i_req.loss_slot] <= i_req.mass_in;
        if (i_cmd.load) begin
            r_m   <= i_req.mass_in;
            r_pos <= i_req.fragment_number;
            r_res <= i_req.residue_code;
            r_z   <= w_z;
        end
        if (i_cmd.prep) begin
            r_base <= n_base;
            r_hm   <= w_prec ? '0 : pfim_pkg::NUM_W'(w_hm_u);
        end
        if (i_cmd.start) begin
            r_quo  <= pfim_pkg::QUO_W'(w_mag);
            r_rem  <= '0;
            r_neg  <= w_num[pfim_pkg::NUM_W-1];
            r_addp <= w_prec && (i_cmd.kind != pfim_pkg::K_RAD0);
            r_var  <= pfim_pkg::variant_of(r_type, i_cmd.kind);
            r_lidx <= (i_cmd.kind == pfim_pkg::K_LOSS) ? i_cmd.idx : '0;
        end else if (i_cmd.step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (i_cmd.finish) begin
            if (w_sum > SAT_HI)
                r_o_mass <= SAT_HI[pfim_pkg::MASS_W-1:0];
            else if (w_sum < SAT_LO)
                r_o_mass <= SAT_LO[pfim_pkg::MASS_W-1:0];
            else
                r_o_mass <= w_sum[pfim_pkg::MASS_W-1:0];
            r_o_var  <= r_var;
            r_o_lidx <= r_lidx;
            r_o_pos  <= w_imm ? '0 : r_pos;
            r_o_chg  <= r_z;
            r_o_res  <= w_imm ? r_res : '0;
            r_o_last <= i_cmd.last;
        end
    end

    assign o_ion.ion_mz       = r_o_mass;
    assign o_ion.variant      = r_o_var;
    assign o_ion.loss_index   = r_o_lidx;
    assign o_ion.ion_position = r_o_pos;
    assign o_ion.ion_charge   = r_o_chg;
    assign o_ion.residue_out  = r_o_res;
    assign o_ion.last_ion     = r_o_last;

endmodule

[rtl/pfim_ctrl.sv]
// Controller: sequences each request through its ions and the divider steps.
module pfim_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_req_type,
    input  logic                i_out_ready,
    input  pfim_pkg::t_status   i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output pfim_pkg::t_cmd      o_cmd
);

    pfim_pkg::t_state              r_state, n_state;
    pfim_pkg::t_kind               r_kind, n_kind;
    logic [pfim_pkg::LOSS_IW-1:0]  r_idx, n_idx;
    logic [pfim_pkg::CNT_W-1:0]    r_cnt;
    logic                          w_more;
    logic                          w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    // Pick the ion that follows the current one
    always_comb begin
        w_more = 1'b0;
        n_kind = pfim_pkg::K_LOSS;
        n_idx  = '0;
        case (r_kind)
            pfim_pkg::K_BASE: begin
                if (i_status.nv != 2'd0) begin
                    w_more = 1'b1;
                    n_kind = pfim_pkg::K_RAD0;
                end else begin
                    w_more = (i_status.nl != '0);
                end
            end
            pfim_pkg::K_RAD0: begin
                if (i_status.nv == 2'd2) begin
                    w_more = 1'b1;
                    n_kind = pfim_pkg::K_RAD1;
                end else begin
                    w_more = (i_status.nl != '0);
                end
            end
            pfim_pkg::K_RAD1: w_more = (i_status.nl != '0);
            default: begin
                w_more = (pfim_pkg::LOSS_CW'(r_idx) + pfim_pkg::LOSS_CW'(1)) < i_status.nl;
                n_idx  = r_idx + pfim_pkg::LOSS_IW'(1);
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfim_pkg::S_IDLE:
                if (w_accept && i_in_req_type == pfim_pkg::REQ_COMPUTE)
                    n_state = pfim_pkg::S_LOAD;
            pfim_pkg::S_LOAD:
                n_state = i_status.skip ? pfim_pkg::S_IDLE : pfim_pkg::S_NUM;
            pfim_pkg::S_NUM:
                n_state = pfim_pkg::S_DIV;
            pfim_pkg::S_DIV:
                if (r_cnt == pfim_pkg::CNT_W'(pfim_pkg::DIV_STEPS - 1))
                    n_state = pfim_pkg::S_FIN;
            pfim_pkg::S_FIN:
                n_state = pfim_pkg::S_OUT;
            pfim_pkg::S_OUT:
                if (i_out_ready)
                    n_state = w_more ? pfim_pkg::S_NUM : pfim_pkg::S_IDLE;
            default:
                n_state = pfim_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_in_ready        = (r_state == pfim_pkg::S_IDLE);
        o_out_valid       = (r_state == pfim_pkg::S_OUT);
        o_cmd.write_loss  = w_accept && (i_in_req_type == pfim_pkg::REQ_LOSS_WR);
        o_cmd.load        = w_accept && (i_in_req_type == pfim_pkg::REQ_COMPUTE);
        o_cmd.prep        = (r_state == pfim_pkg::S_LOAD);
        o_cmd.start       = (r_state == pfim_pkg::S_NUM);
        o_cmd.step        = (r_state == pfim_pkg::S_DIV);
        o_cmd.finish      = (r_state == pfim_pkg::S_FIN);
        o_cmd.kind        = r_kind;
        o_cmd.idx         = r_idx;
        o_cmd.last        = !w_more;
    end

    // Hold state, ion selection and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfim_pkg::S_IDLE;
            r_kind  <= pfim_pkg::K_BASE;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == pfim_pkg::S_LOAD) begin
                r_kind <= pfim_pkg::K_BASE;
                r_idx  <= '0;
            end else if (r_state == pfim_pkg::S_OUT && i_out_ready && w_more) begin
                r_kind <= n_kind;
                r_idx  <= n_idx;
            end
            if (r_state == pfim_pkg::S_DIV)
                r_cnt <= r_cnt + pfim_pkg::CNT_W'(1);
            else
                r_cnt <= '0;
        end
    end

`ifndef SYNTHESIS
    a_fin_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfim_pkg::S_FIN |-> $past(r_state) == pfim_pkg::S_DIV
            && $past(r_cnt) == pfim_pkg::CNT_W'(pfim_pkg::DIV_STEPS - 1))
        else $error("finish without full division");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfim_pkg::S_OUT && !i_out_ready)
            |=> r_state == pfim_pkg::S_OUT && $stable(r_kind) && $stable(r_idx))
        else $error("ion selection moved during stall");
    a_compute_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == pfim_pkg::S_LOAD)
        else $error("accepted compute request not loaded");
    a_loss_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfim_pkg::S_NUM && r_kind == pfim_pkg::K_LOSS)
            |-> pfim_pkg::LOSS_CW'(r_idx) < i_status.nl)
        else $error("loss index beyond entries in use");
`endif

endmodule

[rtl/peptide_fragment_ion_masses.sv]
// Top level of the peptide fragment ion mass generator.
// Usage:
//   i_cfg writes one register per transaction (index, data); it is always ready.
//   Write configuration only while the block is idle.
//   i_req carries one request per transaction. A loss-table write (req_type 0)
//   produces no ion. A compute request (req_type 1) produces zero to eleven
//   ions on o_ion, the final one flagged by last_ion.
//   Sequence: a request is accepted in the idle state; the load state then
//   applies the type's mass correction. Each ion then forms its numerator,
//   passes through the shared radix-256 divider (eight quotient bits per
//   cycle, 56 bits), gets its sign and proton offset and is saturated, and
//   waits on o_ion until the receiver takes it.
//   i_req.ready is low from acceptance of a compute request until its last
//   ion is taken.
//   A stall on o_ion holds the current ion and stops all progress.
//   Synchronous active-low reset returns the configuration registers to their
//   reset values and the controller to idle; the loss table is not cleared.
module peptide_fragment_ion_masses (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfim_cfg_if.sink    i_cfg,
    pfim_req_if.sink    i_req,
    pfim_ion_if.source  o_ion
);

    pfim_pkg::t_cmd     w_cmd;
    pfim_pkg::t_status  w_status;
    logic               w_in_ready;
    logic               w_out_valid;

    // Sequence requests and ions
    pfim_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_req.valid),
        .i_in_req_type (i_req.req_type),
        .i_out_ready   (o_ion.ready),
        .i_status      (w_status),
        .o_in_ready    (w_in_ready),
        .o_out_valid   (w_out_valid),
        .o_cmd         (w_cmd)
    );

    // Compute masses
    pfim_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cfg    (i_cfg),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_ion    (o_ion)
    );

    assign i_req.ready = w_in_ready;
    assign o_ion.valid = w_out_valid;

endmodule

[tb/peptide_fragment_ion_masses_test.sv]
// Testbench for the fragment ion mass block: directed table, then random phases.
module peptide_fragment_ion_masses_test;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam longint DALTON = 64'sd16777216;

    typedef struct {
        logic                               req_type;
        logic signed [pfim_pkg::MASS_W-1:0] mass;
        logic [pfim_pkg::LOSS_IW-1:0]       slot;
        logic [pfim_pkg::POS_W-1:0]         frag;
        logic [pfim_pkg::RES_W-1:0]         residue;
        logic [pfim_pkg::CHG_W-1:0]         charge;
    } t_frag_req;

    typedef struct {
        logic signed [pfim_pkg::MASS_W-1:0] mass;
        logic [pfim_pkg::VAR_W-1:0]         var_code;
        logic [pfim_pkg::LOSS_IW-1:0]       loss_idx;
        logic [pfim_pkg::POS_W-1:0]         pos;
        logic [pfim_pkg::CHG_W-1:0]         charge;
        logic [pfim_pkg::RES_W-1:0]         residue;
        logic                               last;
    } t_ion;

    typedef t_ion t_ion_list[$];

    typedef struct {
        bit                          is_cfg;
        logic [pfim_pkg::CFG_IW-1:0] cfg_idx;
        logic [pfim_pkg::CFG_DW-1:0] cfg_data;
        t_frag_req                   req;
        bit                          has_mass;
        longint                      first_mass;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    pfim_cfg_if cfg ();
    pfim_req_if rq ();
    pfim_ion_if ion ();

    peptide_fragment_ion_masses u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (rq),
        .o_ion   (ion)
    );

    // Predictor state
    pfim_pkg::t_ion_type                pm_type;
    logic                               pm_rad;
    logic [3:0]                         pm_loss_cnt;
    longint                             pm_proton;
    longint                             pm_co;
    longint                             pm_nitrogen;
    logic signed [pfim_pkg::MASS_W-1:0] pm_loss_tab [pfim_pkg::MAX_LOSSES];

    t_ion   pending_ions[$];
    int     errors;
    int     idle_cycles;
    int     hold_left;
    int     burst_left;
    bit     req_high;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [pfim_pkg::MASS_W-1:0] clamp_mass(longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (pfim_pkg::MASS_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[pfim_pkg::MASS_W-1:0];
    endfunction

    // Work out the ions one compute transaction should produce
    function automatic t_ion_list predict_ions(t_frag_req r);
        t_ion_list ions;
        t_ion      it;
        longint    m, p, z, hm, base;
        longint    vm [2];
        logic [pfim_pkg::VAR_W-1:0] vv [2];
        int        nv, nl;
        logic [pfim_pkg::POS_W-1:0] ipos;
        logic [pfim_pkg::RES_W-1:0] rout;
        m = longint'(r.mass);
        p = pm_proton;
        z = (r.charge == 0) ? 1 : (r.charge > pfim_pkg::MAX_CHARGE) ? pfim_pkg::MAX_CHARGE
                                                                    : r.charge;
        nl = (pm_loss_cnt > pfim_pkg::MAX_LOSSES) ? pfim_pkg::MAX_LOSSES : pm_loss_cnt;
        nv = 0;
        ipos = r.frag;
        rout = '0;
        it.charge = z[pfim_pkg::CHG_W-1:0];
        it.last = 1'b0;
        it.loss_idx = '0;
        if (pm_type == pfim_pkg::ION_PREC) begin
            it.pos = r.frag;
            it.residue = '0;
            it.mass = clamp_mass(m / z + p);
            it.var_code = pfim_pkg::VAR_BASE;
            ions = {ions, it};
            if (pm_rad) begin
                it.mass = clamp_mass(m / z);
                it.var_code = pfim_pkg::VAR_PREC_RAD;
                ions = {ions, it};
            end
            for (int i = 0; i < nl; i++) begin
                it.mass = clamp_mass((m - longint'(pm_loss_tab[i])) / z + p);
                it.var_code = pfim_pkg::VAR_LOSS;
                it.loss_idx = pfim_pkg::LOSS_IW'(i);
                ions = {ions, it};
            end
        end else begin
            hm = (z - 1) * p;
            case (pm_type)
                pfim_pkg::ION_B: begin
                    base = m + p; vm[0] = base; vv[0] = pfim_pkg::VAR_RAD_SAME; nv = 1;
                end
                pfim_pkg::ION_Y: base = m + p;
                pfim_pkg::ION_A: begin
                    base = m + p - pm_co;
                    vm[0] = base - p; vv[0] = pfim_pkg::VAR_RAD_MH;
                    vm[1] = base + p; vv[1] = pfim_pkg::VAR_RAD_PH; nv = 2;
                end
                pfim_pkg::ION_C: begin
                    base = m + 4 * p + pm_nitrogen;
                    vm[0] = base + 2 * p; vv[0] = pfim_pkg::VAR_RAD_P2H; nv = 1;
                end
                pfim_pkg::ION_Z: begin
                    base = m - pm_nitrogen - p;
                    vm[0] = base - p; vv[0] = pfim_pkg::VAR_RAD_MH; nv = 1;
                end
                pfim_pkg::ION_X: begin
                    base = m + pm_co - p; vm[0] = base; vv[0] = pfim_pkg::VAR_RAD_SAME;
                    nv = 1;
                end
                default: begin
                    base = m - pm_co + p; ipos = '0; rout = r.residue;
                end
            endcase
            if (!pm_rad) nv = 0;
            // Drop positions too short for this charge
            if (z > 1 && longint'(ipos) < 2 * z - 1) return ions;
            it.pos = ipos;
            it.residue = rout;
            it.mass = clamp_mass((base + hm) / z);
            it.var_code = pfim_pkg::VAR_BASE;
            ions = {ions, it};
            for (int j = 0; j < nv; j++) begin
                it.mass = clamp_mass((vm[j] + hm) / z);
                it.var_code = vv[j];
                ions = {ions, it};
            end
            for (int i = 0; i < nl; i++) begin
                it.mass = clamp_mass((base - longint'(pm_loss_tab[i]) + hm) / z);
                it.var_code = pfim_pkg::VAR_LOSS;
                it.loss_idx = pfim_pkg::LOSS_IW'(i);
                ions = {ions, it};
            end
        end
        ions[ions.size() - 1].last = 1'b1;
        return ions;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Drop valid if the sender is not about to offer another transaction
    task automatic drop_req();
        if (req_high) begin
            rq.valid <= 1'b0;
            req_high = 1'b0;
        end
    endtask

    // Offer one request, record its ions on acceptance, then maybe open a gap
    task automatic send_req(t_frag_req r, bit has_mass = 0, longint first_mass = 0);
        t_ion_list ions;
        int gap;
        rq.valid           <= 1'b1;
        rq.req_type        <= r.req_type;
        rq.mass_in         <= r.mass;
        rq.loss_slot       <= r.slot;
        rq.fragment_number <= r.frag;
        rq.residue_code    <= r.residue;
        rq.charge_state    <= r.charge;
        req_high = 1'b1;
        do @(posedge i_clk); while (!rq.ready);
        if (r.req_type == pfim_pkg::REQ_LOSS_WR) begin
            pm_loss_tab[r.slot] = r.mass;
        end else begin
            ions = predict_ions(r);
            if (has_mass) begin
                if (ions.size() == 0) report_mismatch("directed row predicts no ions");
                else ions[0].mass = first_mass[pfim_pkg::MASS_W-1:0];
            end
            foreach (ions[k]) pending_ions = {pending_ions, ions[k]};
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            drop_req();
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // Hold the sender until every expected ion has come out
    task automatic wait_idle();
        drop_req();
        while (pending_ions.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [pfim_pkg::CFG_IW-1:0] idx,
                             logic [pfim_pkg::CFG_DW-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            pfim_pkg::CFG_ION_TYPE: pm_type = pfim_pkg::t_ion_type'(data[2:0]);
            pfim_pkg::CFG_RAD_EN:   pm_rad = data[0];
            pfim_pkg::CFG_LOSS_CNT: pm_loss_cnt = data[3:0];
            pfim_pkg::CFG_PROTON:   pm_proton = longint'(data);
            pfim_pkg::CFG_CO:       pm_co = longint'(data);
            pfim_pkg::CFG_NITROGEN: pm_nitrogen = longint'(data);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_row req_row(logic rt, longint mass, int slot, int frag, int res,
                                     int chg, bit has_mass = 0, longint first_mass = 0);
        t_row row;
        row.is_cfg = 0;
        row.cfg_idx = '0;
        row.cfg_data = '0;
        row.req.req_type = rt;
        row.req.mass = mass[pfim_pkg::MASS_W-1:0];
        row.req.slot = pfim_pkg::LOSS_IW'(slot);
        row.req.frag = pfim_pkg::POS_W'(frag);
        row.req.residue = pfim_pkg::RES_W'(res);
        row.req.charge = pfim_pkg::CHG_W'(chg);
        row.has_mass = has_mass;
        row.first_mass = first_mass;
        return row;
    endfunction

    function automatic t_row cfg_row(logic [pfim_pkg::CFG_IW-1:0] idx,
                                     logic [pfim_pkg::CFG_DW-1:0] data);
        t_row row;
        row = req_row(pfim_pkg::REQ_COMPUTE, 0, 0, 0, 0, 1);
        row.is_cfg = 1;
        row.cfg_idx = idx;
        row.cfg_data = data;
        return row;
    endfunction

    function automatic t_frag_req random_req();
        t_frag_req r;
        int sel;
        r.req_type = ($urandom_range(0, 9) < 2) ? pfim_pkg::REQ_LOSS_WR : pfim_pkg::REQ_COMPUTE;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            r.mass = {11'b0, $urandom, 5'b0};
        else if (sel < 9)
            r.mass = pfim_pkg::MASS_W'({$urandom, $urandom});
        else
            r.mass = $urandom_range(0, 1) ? {1'b0, {(pfim_pkg::MASS_W-1){1'b1}}}
                                          : {1'b1, {(pfim_pkg::MASS_W-1){1'b0}}};
        if (r.req_type == pfim_pkg::REQ_LOSS_WR && sel < 8)
            r.mass = pfim_pkg::MASS_W'($urandom_range(0, 32'h3FFFFFF));
        r.slot = pfim_pkg::LOSS_IW'($urandom);
        r.residue = pfim_pkg::RES_W'($urandom);
        r.charge = ($urandom_range(0, 9) == 0)
                   ? pfim_pkg::CHG_W'($urandom_range(0, 15))
                   : pfim_pkg::CHG_W'($urandom_range(1, pfim_pkg::MAX_CHARGE));
        r.frag = ($urandom_range(0, 6) == 0) ? pfim_pkg::POS_W'($urandom_range(0, 16))
                                             : pfim_pkg::POS_W'($urandom);
        return r;
    endfunction

    // Receiver: ready pattern of its own, plus long hold-offs on request
    initial ion.ready = 1'b0;
    always @(posedge i_clk) begin
        int mode;
        mode = int'(($time / 1280) % 3);
        if (hold_left > 0) begin
            ion.ready <= 1'b0;
            hold_left--;
        end else if (mode == 0) begin
            ion.ready <= 1'b1;
        end else if (mode == 1) begin
            ion.ready <= $urandom_range(0, 1);
        end else begin
            ion.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Compare each ion transaction with the oldest expected ion
    always @(posedge i_clk) begin
        t_ion want;
        if (i_rst_n && ion.valid && ion.ready) begin
            if (pending_ions.size() == 0) begin
                report_mismatch($sformatf("unexpected ion m/z %0d", ion.ion_mz));
            end else begin
                want = pending_ions.pop_front();
                if (ion.ion_mz !== want.mass)
                    report_mismatch($sformatf("ion m/z %0d, want %0d",
                                              ion.ion_mz, want.mass));
                if (ion.variant !== want.var_code)
                    report_mismatch($sformatf("variant %0d, want %0d",
                                              ion.variant, want.var_code));
                if (ion.loss_index !== want.loss_idx)
                    report_mismatch($sformatf("loss_index %0d, want %0d",
                                              ion.loss_index, want.loss_idx));
                if (ion.ion_position !== want.pos)
                    report_mismatch($sformatf("ion_position %0d, want %0d",
                                              ion.ion_position, want.pos));
                if (ion.ion_charge !== want.charge)
                    report_mismatch($sformatf("ion_charge %0d, want %0d",
                                              ion.ion_charge, want.charge));
                if (ion.residue_out !== want.residue)
                    report_mismatch($sformatf("residue_out %0d, want %0d",
                                              ion.residue_out, want.residue));
                if (ion.last_ion !== want.last)
                    report_mismatch($sformatf("last_ion %0b, want %0b",
                                              ion.last_ion, want.last));
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((rq.valid && rq.ready) || (ion.valid && ion.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_row      rows[$];
        t_frag_req r;
        longint    kda;
        int        n_items;
        errors = 0;
        idle_cycles = 0;
        hold_left = 0;
        burst_left = 0;
        req_high = 0;
        rq.valid = 1'b0;
        rq.req_type = pfim_pkg::REQ_COMPUTE;
        rq.mass_in = '0;
        rq.loss_slot = '0;
        rq.fragment_number = '0;
        rq.residue_code = '0;
        rq.charge_state = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        pm_type = pfim_pkg::ION_B;
        pm_rad = 1'b0;
        pm_loss_cnt = '0;
        pm_proton = longint'(pfim_pkg::PROTON_RST);
        pm_co = longint'(pfim_pkg::CO_RST);
        pm_nitrogen = longint'(pfim_pkg::NITROGEN_RST);
        foreach (pm_loss_tab[i]) pm_loss_tab[i] = '0;
        kda = 1000 * DALTON;

        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, mass extremes, charge clamping, short positions
        rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, 0, 0, 5, 0, 1, 1, 16899296)};
        rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, 64'sh7FFFFFFFFFFF, 0, 1023, 0, 1,
                              1, 64'sh7FFFFFFFFFFF)};
        rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, -64'sh800000000000, 0, 1, 0, 1,
                              1, -64'sh800000000000 + 16899296)};
        rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, kda, 0, 3, 0, 0)};
        rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, kda, 0, 1023, 0, 15)};
        rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, kda, 0, 4, 0, 3)};
        // Fill every loss entry before any is used
        for (int s = 0; s < pfim_pkg::MAX_LOSSES; s++)
            rows = {rows, req_row(pfim_pkg::REQ_LOSS_WR, (s + 1) * 18 * DALTON, s, 0, 0, 1)};
        rows = {rows, cfg_row(pfim_pkg::CFG_ION_TYPE, pfim_pkg::CFG_DW'(pfim_pkg::ION_A))};
        rows = {rows, cfg_row(pfim_pkg::CFG_RAD_EN, pfim_pkg::CFG_DW'(1))};
        rows = {rows, cfg_row(pfim_pkg::CFG_LOSS_CNT, pfim_pkg::CFG_DW'(15))};
        rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, kda, 0, 3, 0, 2)};
        rows = {rows, cfg_row(pfim_pkg::CFG_ION_TYPE, pfim_pkg::CFG_DW'(pfim_pkg::ION_PREC))};
        rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, -kda, 0, 0, 0, 8)};
        rows = {rows, cfg_row(pfim_pkg::CFG_ION_TYPE, pfim_pkg::CFG_DW'(pfim_pkg::ION_IMM))};
        rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, kda, 0, 9, 255, 1)};
        rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, kda, 0, 9, 255, 2)};
        rows = {rows, cfg_row(pfim_pkg::CFG_PROTON, '1)};
        rows = {rows, cfg_row(pfim_pkg::CFG_CO, '0)};
        rows = {rows, cfg_row(pfim_pkg::CFG_NITROGEN, '1)};
        for (int t = pfim_pkg::ION_Y; t <= pfim_pkg::ION_X; t++) begin
            rows = {rows, cfg_row(pfim_pkg::CFG_ION_TYPE, pfim_pkg::CFG_DW'(t))};
            rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, kda, 0, 20, 0, 4)};
        end
        rows = {rows, cfg_row(pfim_pkg::CFG_PROTON, '0)};
        rows = {rows, req_row(pfim_pkg::REQ_COMPUTE, 64'sh7FFFFFFFFFFF, 0, 1023, 0, 8)};

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                wait_idle();
                write_cfg(rows[i].cfg_idx, rows[i].cfg_data);
            end else begin
                send_req(rows[i].req, rows[i].has_mass, rows[i].first_mass);
            end
        end

        // Random phases, each with its own settings
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            write_cfg(pfim_pkg::CFG_ION_TYPE, pfim_pkg::CFG_DW'(ph));
            write_cfg(pfim_pkg::CFG_RAD_EN, pfim_pkg::CFG_DW'($urandom_range(0, 1)));
            write_cfg(pfim_pkg::CFG_LOSS_CNT,
                      pfim_pkg::CFG_DW'((ph == 2) ? 8 : $urandom_range(0, 15)));
            write_cfg(pfim_pkg::CFG_PROTON, (ph == 5) ? '1 : (ph == 6) ? '0
                      : pfim_pkg::CFG_DW'($urandom_range(0, 32'h3FFFFFF)));
            write_cfg(pfim_pkg::CFG_CO, (ph == 6) ? '1 : pfim_pkg::CFG_DW'($urandom));
            write_cfg(pfim_pkg::CFG_NITROGEN, (ph == 7) ? '0 : pfim_pkg::CFG_DW'($urandom));
            if (ph == 3) hold_left = HOLD_CYCLES;
            n_items = 48;
            for (int k = 0; k < n_items; k++) begin
                r = random_req();
                send_req(r);
            end
        end

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[peptide_fragment_ion_masses.f]
rtl/pfim_pkg.sv
rtl/pfim_if.sv
rtl/pfim_dp.sv
rtl/pfim_ctrl.sv
rtl/peptide_fragment_ion_masses.sv
tb/peptide_fragment_ion_masses_test.sv
